/* rtl/core/rmsb_pkg.sv */
`timescale 1ns / 1ps

package rmsb_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 8;
    localparam int LEN_W  = 9;
    localparam int DATA_W = 32;

    typedef logic [OP_W-1:0]          opcode_t;
    typedef logic [IDX_W-1:0]         index_t;
    typedef logic [LEN_W-1:0]         length_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam opcode_t OP_SET   = 2'd0;
    localparam opcode_t OP_QUERY = 2'd1;
    localparam opcode_t OP_READ  = 2'd2;

    localparam length_t LEN_RESET = 9'd256;

endpackage

/* rtl/core/rmsb_req_if.sv */
`timescale 1ns / 1ps

interface rmsb_req_if
    import rmsb_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    index_t  first_index;
    index_t  last_index;
    data_t   new_value;

    modport source (
        output valid,
        output opcode,
        output first_index,
        output last_index,
        output new_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  first_index,
        input  last_index,
        input  new_value,
        output ready
    );
endinterface

/* rtl/core/rmsb_rsp_if.sv */
`timescale 1ns / 1ps

interface rmsb_rsp_if
    import rmsb_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t result_value;
    logic  range_error;

    modport source (
        output valid,
        output result_value,
        output range_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_value,
        input  range_error,
        output ready
    );
endinterface

/* rtl/core/rmsb_ram.sv */
`timescale 1ns / 1ps

module rmsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/range_min_sqrt_blocks_top.sv */
`timescale 1ns / 1ps
// Range-minimum store over up to 256 signed 32-bit elements, split into blocks
// of BLOCK_LENGTH elements with a cached minimum per block.
// req carries one item (set, range query or read); rsp returns one result
// item per request unless a length write drops it: the minimum or element,
// or zero for a set, with range_error raised for a bad index, a reversed
// range or an unused opcode. Any APB write sets array_length, read back at
// address 0, and clears the store. One item is handled at a time and
// req.ready is low until its result is taken. A rejected item shows its
// result on the cycle after acceptance. Otherwise the item steps through
// ST_DIV, ST_OFF, ST_WALK, ST_FINISH and ST_OUT, with one memory read per
// ST_WALK step: a set reads its block (up to BLOCK_LENGTH elements), a read
// one element, a query each element of the partial blocks at both ends plus
// one cache read per whole block, all through one shared compare unit
// fed by the element and block-minimum memories. After reset and after every
// length write a clearing pass zeroes both memories, one entry a cycle up to
// the larger of their two depths, during which no item is accepted.
// A stalled rsp holds its result and keeps req blocked until it is taken.
module range_min_sqrt_blocks_top
    import rmsb_pkg::*;
#(
    parameter int MAX_LENGTH   = 256,
    parameter int BLOCK_LENGTH = 16,
    parameter int BLOCK_COUNT  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rmsb_req_if.sink    req,
    rmsb_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEN_CAP    = (MAX_LENGTH > 256) ? 256 : MAX_LENGTH;
    localparam int ELEM_DEPTH = LEN_CAP;
    localparam int CLR_DEPTH  = (ELEM_DEPTH > BLOCK_COUNT) ? ELEM_DEPTH : BLOCK_COUNT;
    localparam int AW         = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
    localparam int CAW        = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CW         = $clog2(CLR_DEPTH + 1);
    localparam int PW         = 10;
    localparam int BW         = 9;
    localparam int OW         = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
    localparam int SH         = 18;
    localparam int MW         = 19;

    localparam logic [1:0]     ADDR_ARRAY_LENGTH = 2'd0;

    localparam logic [MW-1:0]  DIV_MUL  = MW'((2**SH + BLOCK_LENGTH - 1) / BLOCK_LENGTH);
    localparam logic [PW-1:0]  BL_V     = PW'(BLOCK_LENGTH);
    localparam logic [BW:0]    BC_V     = (BW + 1)'(BLOCK_COUNT);
    localparam logic [OW-1:0]  OFF_LAST = OW'(BLOCK_LENGTH - 1);
    localparam length_t        LEN_MAX  = LEN_W'(LEN_CAP);
    localparam logic [CW-1:0]  CLR_LAST = CW'(CLR_DEPTH - 1);
    localparam logic [CW-1:0]  ELEM_END = CW'(ELEM_DEPTH);
    localparam logic [CW-1:0]  BLK_END  = CW'(BLOCK_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_OFF,
        ST_WALK,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    length_t         len_reg, len_next;
    opcode_t         op_reg, op_next;
    logic [PW-1:0]   lo_reg, lo_next;
    logic [PW-1:0]   hi_reg, hi_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [BW-1:0]   blk_reg, blk_next;
    logic [BW-1:0]   wblk_reg, wblk_next;
    logic [OW-1:0]   off_reg, off_next;
    logic            elem_only_reg, elem_only_next;
    logic            rd_elem_reg, rd_elem_next;
    logic            rd_blk_reg, rd_blk_next;
    data_t           acc_reg, acc_next;
    logic            acc_vld_reg, acc_vld_next;
    data_t           res_reg, res_next;
    logic            err_reg, err_next;
    logic            out_vld_reg, out_vld_next;

    logic            elem_we;
    logic [AW-1:0]   elem_waddr;
    data_t           elem_wdata;
    logic [AW-1:0]   elem_raddr;
    data_t           elem_rdata;
    logic            blk_we;
    logic [CAW-1:0]  blk_waddr;
    data_t           blk_wdata;
    logic [CAW-1:0]  blk_raddr;
    data_t           blk_rdata;

    logic            cfg_wr;
    length_t         len_eff;
    logic [LEN_W-1:0] fi_x, li_x;
    logic            item_ok;
    logic [PW+MW-1:0] prod;
    logic [PW-1:0]   base;
    logic [PW-1:0]   blk_end_pos;
    logic [PW-1:0]   set_hi;
    logic            issue;
    logic            use_cache;
    data_t           rd_data;

    function automatic data_t smin(data_t a, data_t b);
        return (a <= b) ? a : b;
    endfunction

    rmsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ELEM_DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    rmsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BLOCK_COUNT)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ARRAY_LENGTH) ? 32'(len_reg) : '0;
    assign cfg_wr = psel & penable & pwrite;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_vld_reg;
    assign rsp.result_value = res_reg;
    assign rsp.range_error  = err_reg;

    assign len_eff = (len_reg > LEN_MAX) ? LEN_MAX : len_reg;
    assign fi_x    = LEN_W'(req.first_index);
    assign li_x    = LEN_W'(req.last_index);

    always_comb
    begin
        case (req.opcode)
            OP_SET, OP_READ: item_ok = (fi_x < len_eff);
            OP_QUERY:        item_ok = (req.first_index <= req.last_index) && (li_x < len_eff);
            default:         item_ok = 1'b0;
        endcase
    end

    assign prod        = (PW + MW)'(lo_reg) * (PW + MW)'(DIV_MUL);
    assign base        = PW'(blk_reg) * BL_V;
    assign blk_end_pos = base + BL_V;
    assign set_hi      = ((blk_end_pos > PW'(len_eff)) ? PW'(len_eff) : blk_end_pos) - PW'(1);

    assign issue     = (pos_reg <= hi_reg);
    assign use_cache = !elem_only_reg && (off_reg == '0) && ({1'b0, blk_reg} < BC_V)
                       && ((pos_reg + BL_V) <= (hi_reg + PW'(1)));
    assign rd_data   = rd_blk_reg ? blk_rdata : elem_rdata;

    assign elem_raddr = AW'(pos_reg);
    assign blk_raddr  = CAW'(blk_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        len_next       = len_reg;
        op_next        = op_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        blk_next       = blk_reg;
        wblk_next      = wblk_reg;
        off_next       = off_reg;
        elem_only_next = elem_only_reg;
        rd_elem_next   = 1'b0;
        rd_blk_next    = 1'b0;
        acc_next       = acc_reg;
        acc_vld_next   = acc_vld_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_vld_next   = out_vld_reg;

        elem_we    = 1'b0;
        elem_waddr = AW'(req.first_index);
        elem_wdata = req.new_value;
        blk_we     = 1'b0;
        blk_waddr  = CAW'(wblk_reg);
        blk_wdata  = acc_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                elem_we    = (clr_cnt_reg < ELEM_END);
                elem_waddr = AW'(clr_cnt_reg);
                elem_wdata = '0;
                blk_we     = (clr_cnt_reg < BLK_END);
                blk_waddr  = CAW'(clr_cnt_reg);
                blk_wdata  = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (!item_ok)
                    begin
                        res_next     = '0;
                        err_next     = 1'b1;
                        out_vld_next = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        // write the element now, rebuild its block after
                        elem_we        = (req.opcode == OP_SET);
                        op_next        = req.opcode;
                        lo_next        = PW'(req.first_index);
                        hi_next        = (req.opcode == OP_QUERY) ? PW'(req.last_index)
                                                                  : PW'(req.first_index);
                        elem_only_next = (req.opcode != OP_QUERY);
                        acc_vld_next   = 1'b0;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                blk_next   = prod[SH +: BW];
                state_next = ST_OFF;
            end
            ST_OFF:
            begin
                wblk_next = blk_reg;
                if (op_reg == OP_SET)
                begin
                    pos_next = base;
                    off_next = '0;
                    hi_next  = set_hi;
                end
                else
                begin
                    pos_next = lo_reg;
                    off_next = OW'(lo_reg - base);
                end
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (rd_elem_reg || rd_blk_reg)
                begin
                    acc_next     = acc_vld_reg ? smin(acc_reg, rd_data) : rd_data;
                    acc_vld_next = 1'b1;
                end
                if (issue)
                begin
                    if (use_cache)
                    begin
                        rd_blk_next = 1'b1;
                        pos_next    = pos_reg + BL_V;
                        blk_next    = blk_reg + BW'(1);
                    end
                    else
                    begin
                        rd_elem_next = 1'b1;
                        pos_next     = pos_reg + PW'(1);
                        if (off_reg == OFF_LAST)
                        begin
                            off_next = '0;
                            blk_next = blk_reg + BW'(1);
                        end
                        else
                        begin
                            off_next = off_reg + OW'(1);
                        end
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                blk_we       = (op_reg == OP_SET) && ({1'b0, wblk_reg} < BC_V);
                res_next     = (op_reg == OP_SET) ? '0 : acc_reg;
                err_next     = 1'b0;
                out_vld_next = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    out_vld_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_wr)
        begin
            len_next     = pwdata[LEN_W-1:0];
            clr_cnt_next = '0;
            out_vld_next = 1'b0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            len_reg       <= LEN_RESET;
            op_reg        <= OP_SET;
            lo_reg        <= '0;
            hi_reg        <= '0;
            pos_reg       <= '0;
            blk_reg       <= '0;
            wblk_reg      <= '0;
            off_reg       <= '0;
            elem_only_reg <= 1'b0;
            rd_elem_reg   <= 1'b0;
            rd_blk_reg    <= 1'b0;
            acc_reg       <= '0;
            acc_vld_reg   <= 1'b0;
            res_reg       <= '0;
            err_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            len_reg       <= len_next;
            op_reg        <= op_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            pos_reg       <= pos_next;
            blk_reg       <= blk_next;
            wblk_reg      <= wblk_next;
            off_reg       <= off_next;
            elem_only_reg <= elem_only_next;
            rd_elem_reg   <= rd_elem_next;
            rd_blk_reg    <= rd_blk_next;
            acc_reg       <= acc_next;
            acc_vld_reg   <= acc_vld_next;
            res_reg       <= res_next;
            err_reg       <= err_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("item accepted while a result is pending");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !cfg_wr) |=> (!req.ready && (state_reg != ST_CLEAR)))
        else $error("accepted item did not start");

    a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.range_error) |-> (rsp.result_value == '0))
        else $error("error result carries a non-zero value");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (pos_reg <= (hi_reg + PW'(1))))
        else $error("scan position overran the range");

    a_single_read_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_elem_reg && rd_blk_reg))
        else $error("element and block reads issued together");

endmodule
